FILE: hdl/cbez_pkg.sv
package cbez_pkg;

	// Number of equal parameter steps walked by a length search.
	localparam int SEARCH_STEPS = 200;

	localparam int K_W  = $clog2(SEARCH_STEPS + 1);
	localparam int R_W  = $clog2(2 * SEARCH_STEPS);

	localparam logic [16:0]    T_ONE        = 17'h10000;
	localparam logic [16:0]    STEP_Q       = 17'(65536 / SEARCH_STEPS);
	localparam logic [R_W-1:0] STEP_R       = R_W'(65536 % SEARCH_STEPS);
	localparam logic [R_W-1:0] STEP_HALF    = R_W'(SEARCH_STEPS / 2);
	localparam logic [R_W-1:0] STEPS_R      = R_W'(SEARCH_STEPS);
	localparam logic [K_W-1:0] STEPS_K      = K_W'(SEARCH_STEPS);
	localparam logic [K_W-1:0] STEPS_K_LAST = K_W'(SEARCH_STEPS - 1);
	localparam logic [23:0]    LEN_MAX      = 24'hFFFFFF;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_START_X,
		REG_START_Y,
		REG_CTRL1_X,
		REG_CTRL1_Y,
		REG_CTRL2_X,
		REG_CTRL2_Y,
		REG_END_X,
		REG_END_Y
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINAL,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic last;
		logic final_eval;
	} cmd_t;

	typedef struct packed {
		logic search_over;
		logic out_valid;
	} stat_t;

endpackage

FILE: hdl/cubic_bezier_eval_and_arc_search_top.sv
// Sequence: an evaluate word runs from start through the point pipeline to done; a search
// word walks steps until the target is reached at step k or all SEARCH_STEPS chords are summed.
// Throughput: one word at a time; the step walk issues one curve point per cycle through
// the six-stage point pipeline, and the 17-stage square-root pipeline sets the tail.
// Reset: arst_n clears the control points to zero and empties every pipeline at once.
// Results leave on done for one cycle; the receiver cannot stall them.
module cubic_bezier_eval_and_arc_search_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_wdata,
	input  logic                start,
	output logic                busy,
	input  logic                func,
	input  logic signed [17:0]  t_in,
	input  logic [23:0]         target_length,
	output logic                done,
	output logic [16:0]         t_out,
	output logic signed [15:0]  point_x,
	output logic signed [15:0]  point_y
);

	// The controller sequences one word: it loads the operands, for a search word walks the
	// search steps until the datapath reports the target reached or the last chord summed,
	// and then issues one final evaluation whose point is presented on done.
	cbez_pkg::cmd_t  cmd;
	cbez_pkg::stat_t stat;

	cbez_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the control points, the step generator, the curve point
	// pipeline, the chord length pipeline and the saturating length sum.
	cbez_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.func          (func),
		.t_in          (t_in),
		.target_length (target_length),
		.cmd           (cmd),
		.stat          (stat),
		.done          (done),
		.t_out         (t_out),
		.point_x       (point_x),
		.point_y       (point_y)
	);

	// A result word only appears while a word is in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a word in flight");

	// Each word yields exactly one result cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// The returned parameter never exceeds 1.0.
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (t_out <= cbez_pkg::T_ONE))
		else $error("t_out above 1.0");

	// The block goes idle in the cycle after its result is shown.
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy after result");

endmodule

FILE: hdl/cbez_ctrl.sv
module cbez_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             func,
	input  cbez_pkg::stat_t  stat,
	output cbez_pkg::cmd_t   cmd,
	output logic             busy
);

	cbez_pkg::state_t             state_q, state_d;
	logic [cbez_pkg::K_W-1:0]     cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbez_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			cbez_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = func ? cbez_pkg::ST_SEARCH : cbez_pkg::ST_FINAL;
				end
			end
			cbez_pkg::ST_SEARCH: begin
				if (stat.search_over) begin
					state_d = cbez_pkg::ST_FINAL;
				end else if (cnt_q != cbez_pkg::STEPS_K) begin
					cmd.step = 1'b1;
					cmd.last = (cnt_q == cbez_pkg::STEPS_K_LAST);
					cnt_d    = cnt_q + 1'b1;
				end
			end
			cbez_pkg::ST_FINAL: begin
				cmd.final_eval = 1'b1;
				state_d        = cbez_pkg::ST_WAIT;
			end
			cbez_pkg::ST_WAIT: begin
				if (stat.out_valid) begin
					state_d = cbez_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cbez_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != cbez_pkg::ST_IDLE);

endmodule

FILE: hdl/cbez_datapath.sv
module cbez_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_wdata,
	input  logic                func,
	input  logic signed [17:0]  t_in,
	input  logic [23:0]         target_length,
	input  cbez_pkg::cmd_t      cmd,
	output cbez_pkg::stat_t     stat,
	output logic                done,
	output logic [16:0]         t_out,
	output logic signed [15:0]  point_x,
	output logic signed [15:0]  point_y
);

	typedef struct packed {
		logic        v;
		logic        fin;
		logic        last;
		logic [16:0] t;
	} meta_t;

	typedef struct packed {
		logic        v;
		logic        last;
		logic [16:0] t;
		logic [33:0] val;
		logic [19:0] rem;
		logic [16:0] root;
	} sq_stage_t;

	// One restoring step of the integer square root: two radicand bits in, one root bit out.
	function automatic sq_stage_t sq_step(sq_stage_t a);
		sq_stage_t   b;
		logic [19:0] rem2;
		logic [19:0] trial;
		rem2   = {a.rem[17:0], a.val[33:32]};
		trial  = {1'b0, a.root, 2'b01};
		b      = a;
		b.val  = {a.val[31:0], 2'b00};
		if (rem2 >= trial) begin
			b.rem  = rem2 - trial;
			b.root = {a.root[15:0], 1'b1};
		end else begin
			b.rem  = rem2;
			b.root = {a.root[15:0], 1'b0};
		end
		return b;
	endfunction

	logic signed [15:0] cx_q [4];
	logic signed [15:0] cy_q [4];

	logic [16:0]               t_gen_q;
	logic [cbez_pkg::R_W-1:0]  r_q;
	logic [cbez_pkg::R_W-1:0]  r_sum, r_next;
	logic [16:0]               t_next;
	logic [16:0]               t_sel_q;
	logic [16:0]               t_clamp;
	logic [23:0]               target_q;
	logic [23:0]               sum_q;
	logic [24:0]               sum_raw;
	logic [23:0]               sum_sat;
	logic                      found_q, last_done_q;

	meta_t       meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	logic [16:0] u_s1, u_s2, t_s2;
	logic [33:0] u2_s2, t2_s2;
	logic [50:0] p0, p1, p2, p3;
	logic [48:0] w_s3 [4];
	logic signed [65:0] px_s4 [4];
	logic signed [65:0] py_s4 [4];
	logic signed [65:0] sx01_s5, sx23_s5, sy01_s5, sy23_s5;
	logic signed [65:0] acc_x, acc_y;
	logic signed [15:0] pt_x_s6, pt_y_s6;

	logic signed [15:0] prev_x_q, prev_y_q;
	logic               v_c1, last_c1, v_c2, last_c2;
	logic [16:0]        t_c1, t_c2;
	logic signed [16:0] dx_c1, dy_c1;
	logic signed [33:0] sqx, sqy;
	logic [33:0]        sq_c2;
	sq_stage_t          sq_in;
	sq_stage_t          stg_q [17];

	logic               done_q;
	logic [16:0]        t_out_q;
	logic signed [15:0] pt_x_q, pt_y_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				cx_q[i] <= '0;
				cy_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cbez_pkg::reg_idx_t'(cfg_index))
				cbez_pkg::REG_START_X: cx_q[0] <= cfg_wdata;
				cbez_pkg::REG_START_Y: cy_q[0] <= cfg_wdata;
				cbez_pkg::REG_CTRL1_X: cx_q[1] <= cfg_wdata;
				cbez_pkg::REG_CTRL1_Y: cy_q[1] <= cfg_wdata;
				cbez_pkg::REG_CTRL2_X: cx_q[2] <= cfg_wdata;
				cbez_pkg::REG_CTRL2_Y: cy_q[2] <= cfg_wdata;
				cbez_pkg::REG_END_X:   cx_q[3] <= cfg_wdata;
				cbez_pkg::REG_END_Y:   cy_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Step parameter generator: t_k = round(k / SEARCH_STEPS) in Q1.16, kept as quotient and remainder.
	always_comb begin
		r_sum = r_q + cbez_pkg::STEP_R;
		if (r_sum >= cbez_pkg::STEPS_R) begin
			t_next = t_gen_q + cbez_pkg::STEP_Q + 17'd1;
			r_next = r_sum - cbez_pkg::STEPS_R;
		end else begin
			t_next = t_gen_q + cbez_pkg::STEP_Q;
			r_next = r_sum;
		end
	end

	always_comb begin
		if (t_in[17]) begin
			t_clamp = '0;
		end else if (t_in[16:0] > cbez_pkg::T_ONE) begin
			t_clamp = cbez_pkg::T_ONE;
		end else begin
			t_clamp = t_in[16:0];
		end
	end

	always_comb begin
		sum_raw = {1'b0, sum_q} + {8'd0, stg_q[16].root};
		sum_sat = (sum_raw > {1'b0, cbez_pkg::LEN_MAX}) ? cbez_pkg::LEN_MAX : sum_raw[23:0];
	end

	// Search bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			last_done_q <= 1'b0;
		end else if (cmd.load) begin
			found_q     <= 1'b0;
			last_done_q <= 1'b0;
		end else if (stg_q[16].v && !found_q && !last_done_q) begin
			if (sum_sat >= target_q) begin
				found_q <= 1'b1;
			end else if (stg_q[16].last) begin
				last_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_gen_q  <= '0;
			r_q      <= cbez_pkg::STEP_HALF;
			sum_q    <= '0;
			target_q <= target_length;
			t_sel_q  <= func ? cbez_pkg::T_ONE : t_clamp;
			prev_x_q <= cx_q[0];
			prev_y_q <= cy_q[0];
		end else begin
			if (cmd.step) begin
				t_gen_q <= t_next;
				r_q     <= r_next;
			end
			if (stg_q[16].v && !found_q && !last_done_q) begin
				sum_q <= sum_sat;
				if (sum_sat >= target_q) begin
					t_sel_q <= stg_q[16].t;
				end
			end
			if (meta_s6.v && !meta_s6.fin) begin
				prev_x_q <= pt_x_s6;
				prev_y_q <= pt_y_s6;
			end
		end
	end

	always_comb begin
		p0 = u2_s2 * u_s2;
		p1 = u2_s2 * t_s2;
		p2 = t2_s2 * u_s2;
		p3 = t2_s2 * t_s2;
		acc_x = sx01_s5 + sx23_s5 + 66'sh8000_0000_0000;
		acc_y = sy01_s5 + sy23_s5 + 66'sh8000_0000_0000;
		sqx   = dx_c1 * dx_c1;
		sqy   = dy_c1 * dy_c1;
		sq_in      = '0;
		sq_in.v    = v_c2;
		sq_in.last = last_c2;
		sq_in.t    = t_c2;
		sq_in.val  = sq_c2;
	end

	// Point pipeline, chord stages and root pipeline; a load flushes the valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
			meta_s5 <= '0;
			meta_s6 <= '0;
			v_c1    <= 1'b0;
			v_c2    <= 1'b0;
			for (int i = 0; i < 17; i++) begin
				stg_q[i] <= '0;
			end
			done_q <= 1'b0;
		end else begin
			meta_s1.v <= (cmd.step || cmd.final_eval) && !cmd.load;
			meta_s2.v <= meta_s1.v && !cmd.load;
			meta_s3.v <= meta_s2.v && !cmd.load;
			meta_s4.v <= meta_s3.v && !cmd.load;
			meta_s5.v <= meta_s4.v && !cmd.load;
			meta_s6.v <= meta_s5.v && !cmd.load;
			v_c1      <= meta_s6.v && !meta_s6.fin && !cmd.load;
			v_c2      <= v_c1 && !cmd.load;
			stg_q[0].v <= v_c2 && !cmd.load;
			for (int i = 1; i < 17; i++) begin
				stg_q[i].v <= stg_q[i-1].v && !cmd.load;
			end
			done_q <= meta_s6.v && meta_s6.fin;

			meta_s1.fin  <= cmd.final_eval;
			meta_s1.last <= cmd.last;
			meta_s1.t    <= cmd.final_eval ? t_sel_q : t_next;
			u_s1         <= cbez_pkg::T_ONE - (cmd.final_eval ? t_sel_q : t_next);

			{meta_s2.fin, meta_s2.last, meta_s2.t} <= {meta_s1.fin, meta_s1.last, meta_s1.t};
			u_s2  <= u_s1;
			t_s2  <= meta_s1.t;
			u2_s2 <= u_s1 * u_s1;
			t2_s2 <= meta_s1.t * meta_s1.t;

			{meta_s3.fin, meta_s3.last, meta_s3.t} <= {meta_s2.fin, meta_s2.last, meta_s2.t};
			w_s3[0] <= p0[48:0];
			w_s3[1] <= 49'(p1 + (p1 << 1));
			w_s3[2] <= 49'(p2 + (p2 << 1));
			w_s3[3] <= p3[48:0];

			{meta_s4.fin, meta_s4.last, meta_s4.t} <= {meta_s3.fin, meta_s3.last, meta_s3.t};
			for (int i = 0; i < 4; i++) begin
				px_s4[i] <= $signed({1'b0, w_s3[i]}) * cx_q[i];
				py_s4[i] <= $signed({1'b0, w_s3[i]}) * cy_q[i];
			end

			{meta_s5.fin, meta_s5.last, meta_s5.t} <= {meta_s4.fin, meta_s4.last, meta_s4.t};
			sx01_s5 <= px_s4[0] + px_s4[1];
			sx23_s5 <= px_s4[2] + px_s4[3];
			sy01_s5 <= py_s4[0] + py_s4[1];
			sy23_s5 <= py_s4[2] + py_s4[3];

			{meta_s6.fin, meta_s6.last, meta_s6.t} <= {meta_s5.fin, meta_s5.last, meta_s5.t};
			pt_x_s6 <= acc_x[63:48];
			pt_y_s6 <= acc_y[63:48];

			last_c1 <= meta_s6.last;
			t_c1    <= meta_s6.t;
			dx_c1   <= {pt_x_s6[15], pt_x_s6} - {prev_x_q[15], prev_x_q};
			dy_c1   <= {pt_y_s6[15], pt_y_s6} - {prev_y_q[15], prev_y_q};

			last_c2 <= last_c1;
			t_c2    <= t_c1;
			sq_c2   <= 34'(sqx + sqy);

			{stg_q[0].last, stg_q[0].t, stg_q[0].val, stg_q[0].rem, stg_q[0].root}
				<= {sq_step(sq_in).last, sq_step(sq_in).t, sq_step(sq_in).val,
				    sq_step(sq_in).rem, sq_step(sq_in).root};
			for (int i = 1; i < 17; i++) begin
				{stg_q[i].last, stg_q[i].t, stg_q[i].val, stg_q[i].rem, stg_q[i].root}
					<= {sq_step(stg_q[i-1]).last, sq_step(stg_q[i-1]).t,
					    sq_step(stg_q[i-1]).val, sq_step(stg_q[i-1]).rem,
					    sq_step(stg_q[i-1]).root};
			end

			if (meta_s6.v && meta_s6.fin) begin
				t_out_q <= meta_s6.t;
				pt_x_q  <= pt_x_s6;
				pt_y_q  <= pt_y_s6;
			end
		end
	end

	assign stat.search_over = found_q || last_done_q;
	assign stat.out_valid   = done_q;
	assign done    = done_q;
	assign t_out   = t_out_q;
	assign point_x = pt_x_q;
	assign point_y = pt_y_q;

endmodule
